// File: hdl/pmtpid_pkg.sv
// ----------------------------------------------------------------------------
// PMT section PID extractor package
// Word types for the byte input and the PID result, MPEG-TS stream type codes
// and the fixed byte positions of the program map section header.
// ----------------------------------------------------------------------------
package pmtpid_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
  } pmtpid_in_t;

  typedef struct packed {
    logic [12:0] pid;
    logic        pid_kind;
  } pmtpid_out_t;

  // Result kinds.
  localparam logic KIND_VIDEO = 1'b0;
  localparam logic KIND_PCR   = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_VIDEO_EN = 1'b0;
  localparam logic CFG_PCR_EN   = 1'b1;

  // Stream types reported as video.
  localparam logic [7:0] ST_MPEG1_VIDEO = 8'h01;
  localparam logic [7:0] ST_MPEG2_VIDEO = 8'h02;
  localparam logic [7:0] ST_MPEG4_VIDEO = 8'h10;
  localparam logic [7:0] ST_AVC_VIDEO   = 8'h1B;
  localparam logic [7:0] ST_AVS_VIDEO   = 8'h42;

  // Byte positions inside the section, counted from the first byte at zero.
  localparam logic [12:0] POS_LEN_HI  = 13'd1;
  localparam logic [12:0] POS_LEN_LO  = 13'd2;
  localparam logic [12:0] POS_CUR     = 13'd5;
  localparam logic [12:0] POS_PCR_HI  = 13'd8;
  localparam logic [12:0] POS_PCR_LO  = 13'd9;
  localparam logic [12:0] POS_PIL_HI  = 13'd10;
  localparam logic [12:0] POS_PIL_LO  = 13'd11;
  localparam logic [12:0] POS_LOOP    = 13'd12;
  localparam logic [12:0] HDR_OVERHEAD = 13'd13;
  // Last possible section byte: 2 + maximum section length.
  localparam logic [12:0] POS_MAX     = 13'd4097;

  function automatic logic is_video_type(input logic [7:0] st);
    return (st == ST_MPEG1_VIDEO) || (st == ST_MPEG2_VIDEO) ||
           (st == ST_MPEG4_VIDEO) || (st == ST_AVC_VIDEO) ||
           (st == ST_AVS_VIDEO);
  endfunction

endpackage

// File: hdl/pmt_section_pid_extractor.sv
// ----------------------------------------------------------------------------
// PMT section PID extractor
// Parses a program map section byte by byte and reports video elementary
// PIDs and a separate PCR PID.
// ----------------------------------------------------------------------------
// The block takes one section byte per clock cycle while the result register
// is empty or being emptied, and answers each byte with at most one PID word
// in the next cycle; while the receiver stalls a held word, bytes wait, else
// a stream of bytes runs at a full byte per cycle. All header and loop
// tracking state in the state registers is updated once per byte. A byte flagged as
// section start opens a new section and drops any section in progress. Video
// PIDs (stream types 0x01, 0x02, 0x10, 0x1B, 0x42) come out as each loop
// entry's fifth header byte arrives; the PCR PID comes out on the last
// section byte if no entry carried it. Sections that are not current report
// nothing.
module pmt_section_pid_extractor
  import pmtpid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pmtpid_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pmtpid_out_t out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i
);

  // Position inside one loop entry.
  localparam logic [2:0] OFS_TYPE    = 3'd0;
  localparam logic [2:0] OFS_PID_HI  = 3'd1;
  localparam logic [2:0] OFS_PID_LO  = 3'd2;
  localparam logic [2:0] OFS_INFO_HI = 3'd3;
  localparam logic [2:0] OFS_INFO_LO = 3'd4;
  localparam logic [2:0] OFS_DESC    = 3'd5;

  logic        video_en_q, pcr_en_q;
  logic [12:0] pos_q, pos_d;
  logic        active_q, active_d;
  logic        cur_q, cur_d;
  logic [11:0] sec_len_q, sec_len_d;
  logic [12:0] pcr_q, pcr_d;
  logic [11:0] pil_q, pil_d;
  logic [12:0] loop_q, loop_d;
  logic [2:0]  ofs_q, ofs_d;
  logic [7:0]  st_q, st_d;
  logic [12:0] epid_q, epid_d;
  logic [11:0] eil_q, eil_d;
  logic        matched_q, matched_d;

  logic        out_valid_q;
  pmtpid_out_t out_q;
  logic        res_valid;
  pmtpid_out_t res;
  logic        in_fire;
  logic        stop;
  logic [11:0] eil_dec;
  logic [12:0] loop_need;
  logic [7:0]  b;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign b           = in_data_i.data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_en_q <= 1'b1;
      pcr_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VIDEO_EN: video_en_q <= cfg_data_i;
        CFG_PCR_EN:   pcr_en_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d     = pos_q;
    active_d  = active_q;
    cur_d     = cur_q;
    sec_len_d = sec_len_q;
    pcr_d     = pcr_q;
    pil_d     = pil_q;
    loop_d    = loop_q;
    ofs_d     = ofs_q;
    st_d      = st_q;
    epid_d    = epid_q;
    eil_d     = eil_q;
    matched_d = matched_q;
    res_valid = 1'b0;
    res       = '0;
    stop      = 1'b0;
    eil_dec   = eil_q;
    loop_need = HDR_OVERHEAD + {1'b0, pil_q};

    if (in_fire) begin
      if (in_data_i.section_start) begin
        pos_d     = '0;
        active_d  = 1'b1;
        cur_d     = 1'b0;
        sec_len_d = '0;
        pcr_d     = '0;
        pil_d     = '0;
        loop_d    = '0;
        ofs_d     = OFS_TYPE;
        st_d      = '0;
        epid_d    = '0;
        eil_d     = '0;
        matched_d = 1'b0;
      end else if (active_q) begin
        pos_d = pos_q + 13'd1;

        unique case (pos_d)
          POS_LEN_HI: sec_len_d = {b[3:0], 8'h00};
          POS_LEN_LO: sec_len_d = sec_len_q | {4'h0, b};
          POS_CUR: begin
            cur_d = b[0];
            if (!b[0]) begin
              active_d = 1'b0;
              stop     = 1'b1;
            end
          end
          POS_PCR_HI: pcr_d = {b[4:0], 8'h00};
          POS_PCR_LO: pcr_d = pcr_q | {5'h00, b};
          POS_PIL_HI: pil_d = {b[3:0], 8'h00};
          POS_PIL_LO: begin
            pil_d     = pil_q | {4'h0, b};
            loop_need = HDR_OVERHEAD + {1'b0, pil_d};
            // A negative loop length clamps to zero.
            if ({1'b0, sec_len_q} >= loop_need) begin
              loop_d = {1'b0, sec_len_q} - loop_need;
            end else begin
              loop_d = '0;
            end
          end
          default: ;
        endcase

        if (!stop) begin
          // Elementary stream loop, after the program descriptors.
          if (pos_d >= POS_LOOP && pos_d >= POS_LOOP + {1'b0, pil_q} &&
              loop_q != '0) begin
            loop_d = loop_q - 13'd1;
            if (ofs_q == OFS_DESC) begin
              if (eil_q != '0) begin
                eil_dec = eil_q - 12'd1;
              end
              eil_d = eil_dec;
              if (eil_dec == '0) begin
                ofs_d = OFS_TYPE;
              end
            end else begin
              case (ofs_q)
                OFS_TYPE:    st_d   = b;
                OFS_PID_HI:  epid_d = {b[4:0], 8'h00};
                OFS_PID_LO:  epid_d = epid_q | {5'h00, b};
                OFS_INFO_HI: eil_d  = {b[3:0], 8'h00};
                default: begin
                  eil_d = eil_q | {4'h0, b};
                  if (is_video_type(st_q) && video_en_q) begin
                    res_valid    = 1'b1;
                    res.pid      = epid_q;
                    res.pid_kind = KIND_VIDEO;
                  end
                  if (epid_q == pcr_q) begin
                    matched_d = 1'b1;
                  end
                end
              endcase
              if (ofs_q < OFS_INFO_LO) begin
                ofs_d = ofs_q + 3'd1;
              end else begin
                ofs_d = (eil_d == '0) ? OFS_TYPE : OFS_DESC;
              end
            end
          end

          // Last byte of the section.
          if (pos_d >= POS_LEN_LO && pos_d == POS_LEN_LO + {1'b0, sec_len_d}) begin
            active_d = 1'b0;
            if (pos_d >= POS_PCR_LO && cur_d && !matched_d && pcr_en_q && !res_valid) begin
              res_valid    = 1'b1;
              res.pid      = pcr_d;
              res.pid_kind = KIND_PCR;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      active_q  <= 1'b0;
      cur_q     <= 1'b0;
      sec_len_q <= '0;
      pcr_q     <= '0;
      pil_q     <= '0;
      loop_q    <= '0;
      ofs_q     <= OFS_TYPE;
      st_q      <= '0;
      epid_q    <= '0;
      eil_q     <= '0;
      matched_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      active_q  <= active_d;
      cur_q     <= cur_d;
      sec_len_q <= sec_len_d;
      pcr_q     <= pcr_d;
      pil_q     <= pil_d;
      loop_q    <= loop_d;
      ofs_q     <= ofs_d;
      st_q      <= st_d;
      epid_q    <= epid_d;
      eil_q     <= eil_d;
      matched_q <= matched_d;
    end
  end

  // Result register: the next byte is taken while this word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  // A new word only ever follows an accepted byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_fire))
    else $error("result word appeared without an accepted byte");

  // A PCR report closes the section.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_valid && res.pid_kind == KIND_PCR) |=> !active_q)
    else $error("section still open after PCR report");

  // An open section never runs past its longest possible length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> pos_q <= POS_MAX)
    else $error("byte position beyond section end");

  // Entry offset stays within the entry layout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ofs_q <= OFS_DESC)
    else $error("entry offset out of range");

endmodule

// File: sim/pmtpid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PMT section PID extractor checker
// Watches the byte and PID channels and predicts the PID words from the
// accepted bytes and the register writes. Each PID word that leaves the block
// is compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module pmtpid_checker
  import pmtpid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  pmtpid_in_t  in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  pmtpid_out_t out_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  output int          pending_o,
  output int          mismatch_count_o
);

  localparam int REPORT_LIMIT = 10;

  // Where the parser stands inside one elementary stream entry.
  typedef enum logic [2:0] {
    ES_TYPE, ES_PID_HI, ES_PID_LO, ES_INFO_HI, ES_INFO_LO, ES_SKIP
  } es_phase_e;

  logic        video_en;
  logic        pcr_en;

  logic [12:0] pos;
  logic        active;
  logic        current;
  logic [11:0] sec_len;
  logic [12:0] pcr_pid;
  logic [11:0] prog_info_len;
  logic [12:0] loop_left;
  es_phase_e   es_phase;
  logic [7:0]  es_type;
  logic [12:0] es_pid;
  logic [11:0] es_info_left;
  logic        pcr_seen;

  pmtpid_out_t pid_reports_q[$];

  task automatic clear_section();
    pos           = '0;
    active        = 1'b0;
    current       = 1'b0;
    sec_len       = '0;
    pcr_pid       = '0;
    prog_info_len = '0;
    loop_left     = '0;
    es_phase      = ES_TYPE;
    es_type       = '0;
    es_pid        = '0;
    es_info_left  = '0;
    pcr_seen      = 1'b0;
  endtask

  // Advances the section parser by one byte; has_pid tells whether the byte
  // produces a PID word.
  task automatic parse_pmt_byte(input pmtpid_in_t w, output logic has_pid,
                                output pmtpid_out_t pid_word);
    logic [7:0] b;
    int         p;
    int         loop_len;
    has_pid  = 1'b0;
    pid_word = '0;
    b        = w.data_byte;
    if (w.section_start) begin
      clear_section();
      active = 1'b1;
      return;
    end
    if (!active) return;

    pos = pos + 13'd1;
    p   = int'(pos);
    case (pos)
      POS_LEN_HI: sec_len = {b[3:0], 8'h00};
      POS_LEN_LO: sec_len[7:0] = b;
      POS_CUR: begin
        current = b[0];
        if (!current) begin
          active = 1'b0;
          return;
        end
      end
      POS_PCR_HI: pcr_pid = {b[4:0], 8'h00};
      POS_PCR_LO: pcr_pid[7:0] = b;
      POS_PIL_HI: prog_info_len = {b[3:0], 8'h00};
      POS_PIL_LO: begin
        prog_info_len[7:0] = b;
        loop_len = int'(sec_len) - int'(HDR_OVERHEAD) - int'(prog_info_len);
        loop_left = (loop_len > 0) ? 13'(loop_len) : '0;
      end
      default: ;
    endcase

    // Elementary stream loop, once the program descriptors are behind.
    if (p >= int'(POS_LOOP) + int'(prog_info_len) && loop_left != '0) begin
      loop_left = loop_left - 13'd1;
      case (es_phase)
        ES_TYPE: begin
          es_type  = b;
          es_phase = ES_PID_HI;
        end
        ES_PID_HI: begin
          es_pid   = {b[4:0], 8'h00};
          es_phase = ES_PID_LO;
        end
        ES_PID_LO: begin
          es_pid[7:0] = b;
          es_phase    = ES_INFO_HI;
        end
        ES_INFO_HI: begin
          es_info_left = {b[3:0], 8'h00};
          es_phase     = ES_INFO_LO;
        end
        ES_INFO_LO: begin
          es_info_left[7:0] = b;
          if (video_en && (es_type inside {ST_MPEG1_VIDEO, ST_MPEG2_VIDEO,
                                           ST_MPEG4_VIDEO, ST_AVC_VIDEO,
                                           ST_AVS_VIDEO})) begin
            has_pid           = 1'b1;
            pid_word.pid      = es_pid;
            pid_word.pid_kind = KIND_VIDEO;
          end
          if (es_pid == pcr_pid) pcr_seen = 1'b1;
          es_phase = (es_info_left == '0) ? ES_TYPE : ES_SKIP;
        end
        default: begin
          if (es_info_left != '0) es_info_left = es_info_left - 12'd1;
          if (es_info_left == '0) es_phase = ES_TYPE;
        end
      endcase
    end

    // Last byte of the section.
    if (p >= int'(POS_LEN_LO) && p == int'(POS_LEN_LO) + int'(sec_len)) begin
      active = 1'b0;
      if (p >= int'(POS_PCR_LO) && current && !pcr_seen && pcr_en && !has_pid) begin
        has_pid           = 1'b1;
        pid_word.pid      = pcr_pid;
        pid_word.pid_kind = KIND_PCR;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pmtpid_out_t want;
    pmtpid_out_t seen;
    logic        has_pid;
    if (!rst_ni) begin
      clear_section();
      video_en = 1'b1;
      pcr_en   = 1'b1;
      pid_reports_q.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = out_data_i;
        if (pid_reports_q.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT)
            $display("%0t: unexpected PID word pid=0x%04h kind=%0d", $realtime,
                     seen.pid, seen.pid_kind);
          mismatch_count_o++;
        end else begin
          want = pid_reports_q.pop_front();
          if (seen.pid !== want.pid || seen.pid_kind !== want.pid_kind) begin
            if (mismatch_count_o < REPORT_LIMIT)
              $display("%0t: PID word mismatch: expected pid=0x%04h kind=%0d, got pid=0x%04h kind=%0d",
                       $realtime, want.pid, want.pid_kind, seen.pid, seen.pid_kind);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_pmt_byte(in_data_i, has_pid, want);
        if (has_pid) pid_reports_q.push_back(want);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_VIDEO_EN) video_en = cfg_data_i;
        else pcr_en = cfg_data_i;
      end
      pending_o = pid_reports_q.size();
    end
  end

endmodule

// File: sim/tb_pmt_section_pid_extractor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PMT section PID extractor testbench
// Feeds program map sections byte by byte, mostly well formed with random
// content, plus short, not current, corrupted and cut off sections, under
// several register settings. The checker beside the block predicts and
// compares every PID word.
// ----------------------------------------------------------------------------
module tb_pmt_section_pid_extractor;
  import pmtpid_pkg::*;

  localparam int          CLK_HALF          = 6;
  localparam int          RESET_CYCLES      = 9;
  localparam int          ITEMS_PER_SETTING = 400;
  localparam int          NUM_SETTINGS      = 5;
  localparam int          HOLD_OFF_CYCLES   = 400;
  localparam int          DRAIN_CYCLES      = 8;
  localparam int unsigned CYCLE_LIMIT       = 200000;
  localparam int          IDLE_PERCENT      = 14;
  localparam logic [7:0]  TID_PMT           = 8'h02;

  typedef enum logic [1:0] {
    SEC_GOOD, SEC_NOT_CURRENT, SEC_BAD_LENGTHS, SEC_SHORT
  } section_shape_e;

  localparam logic [7:0] VIDEO_TYPES [5] = '{ST_MPEG1_VIDEO, ST_MPEG2_VIDEO,
                                             ST_MPEG4_VIDEO, ST_AVC_VIDEO,
                                             ST_AVS_VIDEO};
  localparam logic SETTING_VIDEO [NUM_SETTINGS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam logic SETTING_PCR   [NUM_SETTINGS] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pmtpid_in_t  in_data;
  logic        out_valid;
  logic        out_ready;
  pmtpid_out_t out_data;
  logic        cfg_we;
  logic        cfg_idx;
  logic        cfg_data;

  int          pending_pids;
  int          mismatches;
  int          items_sent;
  int unsigned cycle_count;
  logic        quiet;
  logic        stall_request;
  logic [7:0]  pmt_bytes[$];

  pmt_section_pid_extractor i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pmtpid_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending_pids),
    .mismatch_count_o(mismatches)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // PID receiver: random stalls, plus one long hold-off so that the block
  // fills up and pushes back on the byte side.
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        stall_request = 1'b0;
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic start);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid                <= 1'b1;
    in_data.data_byte       <= b;
    in_data.section_start   <= start;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sends the first count bytes of the built section, the first one flagged
  // as section start.
  task automatic send_section(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(pmt_bytes[i], i == 0);
      items_sent++;
    end
  endtask

  task automatic build_pmt_section(input section_shape_e shape);
    logic [12:0] pcr;
    logic [12:0] es_pid;
    logic [11:0] pil_count;
    logic [11:0] pil_field;
    logic [11:0] len_field;
    logic [11:0] info_len;
    logic [7:0]  es_loop[$];
    int          n_entries;
    pmt_bytes.delete();
    pcr       = 13'($urandom);
    pil_count = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(7, 40))
                                            : 12'($urandom_range(0, 6));
    n_entries = $urandom_range(0, 4);
    for (int e = 0; e < n_entries; e++) begin
      if ($urandom_range(0, 1)) es_loop.push_back(VIDEO_TYPES[$urandom_range(0, 4)]);
      else es_loop.push_back(8'($urandom));
      es_pid   = ($urandom_range(0, 3) == 0) ? pcr : 13'($urandom);
      info_len = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(5, 12))
                                             : 12'($urandom_range(0, 3));
      es_loop.push_back({3'($urandom), es_pid[12:8]});
      es_loop.push_back(es_pid[7:0]);
      es_loop.push_back({4'($urandom), info_len[11:8]});
      es_loop.push_back(info_len[7:0]);
      repeat (info_len) es_loop.push_back(8'($urandom));
    end
    // Now and then the last one to four loop bytes are dropped, so the loop can end inside an entry.
    if (es_loop.size() > 0 && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 4)) if (es_loop.size() > 0) void'(es_loop.pop_back());

    len_field = 12'(9 + pil_count + es_loop.size() + 4);
    pil_field = pil_count;
    if (shape == SEC_BAD_LENGTHS) begin
      len_field = ($urandom_range(0, 3) == 0) ? 12'hFFF : 12'($urandom);
      pil_field = ($urandom_range(0, 3) == 0) ? 12'hFFF : 12'($urandom);
    end else if (shape == SEC_SHORT) begin
      len_field = 12'($urandom_range(0, 12));
    end

    pmt_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : TID_PMT);
    pmt_bytes.push_back({4'($urandom), len_field[11:8]});
    pmt_bytes.push_back(len_field[7:0]);
    pmt_bytes.push_back(8'($urandom));
    pmt_bytes.push_back(8'($urandom));
    pmt_bytes.push_back({7'($urandom), shape != SEC_NOT_CURRENT});
    pmt_bytes.push_back(8'($urandom));
    pmt_bytes.push_back(8'($urandom));
    pmt_bytes.push_back({3'($urandom), pcr[12:8]});
    pmt_bytes.push_back(pcr[7:0]);
    pmt_bytes.push_back({4'($urandom), pil_field[11:8]});
    pmt_bytes.push_back(pil_field[7:0]);
    repeat (pil_count) pmt_bytes.push_back(8'($urandom));
    foreach (es_loop[i]) pmt_bytes.push_back(es_loop[i]);
    repeat (4) pmt_bytes.push_back(8'($urandom));
    if (shape == SEC_SHORT)
      while (pmt_bytes.size() > 3 + int'(len_field)) void'(pmt_bytes.pop_back());
  endtask

  // Stops offering bytes and waits until every predicted word is out and the
  // block has had time to finish its last byte.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pids != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_settings(input logic video, input logic pcr);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_VIDEO_EN;
    cfg_data <= video;
    @(negedge clk);
    cfg_idx  <= CFG_PCR_EN;
    cfg_data <= pcr;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    int             target;
    int             pick;
    section_shape_e shape;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_VIDEO_EN;
    cfg_data      = 1'b0;
    quiet         = 1'b0;
    stall_request = 1'b0;
    items_sent    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Bytes with no section open are dropped.
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    // A zero length field ends the section right at that field.
    pmt_bytes = '{TID_PMT, 8'hB0, 8'h00};
    send_section(3);
    // Maximum section length, but not current: nothing comes out.
    pmt_bytes = '{TID_PMT, 8'hBF, 8'hFF, 8'h00, 8'h01, 8'hC0};
    send_section(6);
    // The section ends right at the PCR PID low byte: PCR reported alone.
    pmt_bytes = '{TID_PMT, 8'hB0, 8'h07, 8'h00, 8'h01, 8'hC1, 8'h00, 8'h00,
                  8'hFF, 8'hFF};
    send_section(10);

    stall_request = 1'b1;
    for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
      if (phase > 0) begin
        settle();
        program_settings(SETTING_VIDEO[phase], SETTING_PCR[phase]);
      end
      quiet  = (phase == 2);
      target = items_sent + ITEMS_PER_SETTING;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        shape = (pick < 70) ? SEC_GOOD :
                (pick < 78) ? SEC_NOT_CURRENT :
                (pick < 86) ? SEC_BAD_LENGTHS : SEC_SHORT;
        build_pmt_section(shape);
        // Some sections are cut off by the next section start.
        if ($urandom_range(0, 11) == 0)
          send_section($urandom_range(1, pmt_bytes.size()));
        else
          send_section(pmt_bytes.size());
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/pmtpid_pkg.sv
hdl/pmt_section_pid_extractor.sv
sim/pmtpid_checker.sv
sim/tb_pmt_section_pid_extractor.sv
